// File: sv/ttt_pkg.sv
// Package for the time-triggered task table.
// Holds command and status codes, the slot record and the slot update bundle.
// No dependencies.
package ttt_pkg;

  localparam int ID_W        = 8;
  localparam int TIME_W      = 16;
  localparam int MAX_RESULTS = 8;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

  typedef enum logic [1:0] {
    CMD_ADD      = 2'd0,
    CMD_REMOVE   = 2'd1,
    CMD_TICK     = 2'd2,
    CMD_DISPATCH = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_t;

  // One task slot as it is kept in the slot memory.
  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] due;
    logic [TIME_W-1:0] period;
    logic              periodic;
    logic              ready;
  } slot_t;

  // What the update logic decides for the slot under the scan pointer.
  typedef struct packed {
    logic  we;
    logic  hit;
    logic  occupied;
    slot_t wdata;
  } upd_t;

endpackage

// File: sv/ttt_slot_update.sv
// Read-modify-write logic for one task slot of the time-triggered task table.
// Depends on ttt_pkg for the command codes, the slot record and upd_t.
module ttt_slot_update (
  input  ttt_pkg::cmd_t                 cmd,
  input  ttt_pkg::slot_t                slot,
  input  logic [ttt_pkg::ID_W-1:0]      task_id,
  input  logic [ttt_pkg::TIME_W-1:0]    period,
  input  logic [ttt_pkg::TIME_W-1:0]    start_delay,
  input  logic                          repeat_periodic,
  input  logic [ttt_pkg::TIME_W-1:0]    tick_count,
  input  logic                          found,
  input  logic                          room,
  output ttt_pkg::upd_t                 upd
);
  import ttt_pkg::*;

  slot_t fresh;
  slot_t ticked;
  slot_t taken;

  // Candidate records for each command.
  always_comb begin
    fresh          = '0;
    fresh.id       = task_id;
    fresh.due      = start_delay + tick_count + TIME_W'(1);
    fresh.period   = period;
    fresh.periodic = repeat_periodic;
    fresh.ready    = 1'b0;

    ticked       = slot;
    ticked.ready = 1'b1;
    ticked.due   = slot.due + slot.period;

    // A dispatched one-shot slot is freed completely.
    taken       = slot;
    taken.ready = 1'b0;
    if (!slot.periodic) begin
      taken = '0;
    end
  end

  // Decide whether this slot is hit and what goes back into memory.
  always_comb begin
    upd          = '0;
    upd.occupied = (slot.id != '0);
    case (cmd)
      CMD_ADD: begin
        upd.hit   = (slot.id == '0);
        upd.wdata = fresh;
      end
      CMD_REMOVE: begin
        upd.hit      = !found && (slot.id == task_id);
        upd.wdata    = '0;
        upd.occupied = (slot.id != '0) && !upd.hit;
      end
      CMD_TICK: begin
        upd.hit   = (slot.id != '0) && (slot.due == tick_count);
        upd.wdata = ticked;
      end
      CMD_DISPATCH: begin
        upd.hit   = slot.ready && room;
        upd.wdata = taken;
      end
      default: begin
        upd.hit = 1'b0;
      end
    endcase
    upd.we = upd.hit;
  end

endmodule

// File: sv/time_triggered_task_table.sv
// Time-triggered task table: slot memory, scan sequencer and result registers.
// Depends on ttt_pkg and ttt_slot_update.
//
//  channel   | handshake               | fields
//  ----------+-------------------------+-----------------------------------------------
//  command   | start && !busy          | cmd, task_id, period, start_delay,
//            |                         | repeat_periodic
//  result    | strobe (one cycle)      | status, run_valid, run_task_id, last,
//            |                         | ticking_on, tick_count
//
// A command walks the slot memory one slot per cycle: an accept step, a scan of
// up to NUM_SLOTS slots and a finish step. Add stops at the first free slot,
// dispatch after MAX_RESULTS ready slots, and a tick while ticking is off answers
// at the accept edge itself. Reset clears the control state and the per-slot
// valid bits at once; there is no clearing pass. Results cannot be stalled: each
// beat shows for exactly one cycle.
module time_triggered_task_table #(
  parameter int NUM_SLOTS = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   cmd,
  input  logic [ttt_pkg::ID_W-1:0]     task_id,
  input  logic [ttt_pkg::TIME_W-1:0]   period,
  input  logic [ttt_pkg::TIME_W-1:0]   start_delay,
  input  logic                         repeat_periodic,
  output logic                         strobe,
  output logic [1:0]                   status,
  output logic                         run_valid,
  output logic [ttt_pkg::ID_W-1:0]     run_task_id,
  output logic                         last,
  output logic                         ticking_on,
  output logic [ttt_pkg::TIME_W-1:0]   tick_count
);
  import ttt_pkg::*;

  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_FINISH = 3'b100
  } state_t;

  state_t               state;
  logic [IDX_W-1:0]     idx;
  logic [IDX_W-1:0]     raddr;
  cmd_t                 cmd_q;
  logic [ID_W-1:0]      id_q;
  logic [TIME_W-1:0]    period_q;
  logic [TIME_W-1:0]    delay_q;
  logic                 rep_q;
  status_t              status_q;
  logic                 any_occ;
  logic [CNT_W-1:0]     n_cnt;
  logic                 pend_valid;
  logic [ID_W-1:0]      pend_id;
  logic [TIME_W-1:0]    tick_counter;
  logic                 ticking_enabled;

  slot_t                slot_mem [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] slot_vld;
  slot_t                rdata;
  logic                 rvld;
  slot_t                slot_rd;
  upd_t                 upd;
  logic                 mem_we;
  logic                 accept;
  logic                 occ_after;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  // Read address: slot 0 while idle, the following slot while scanning.
  always_comb begin
    raddr = '0;
    if (state == S_SCAN && idx != LAST_IDX) begin
      raddr = idx + IDX_W'(1);
    end
  end

  // Slot memory with registered read; never-written entries read as free slots.
  always_ff @(posedge clk) begin
    rdata <= slot_mem[raddr];
    if (mem_we) begin
      slot_mem[idx] <= upd.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_vld <= '0;
      rvld     <= 1'b0;
    end else begin
      rvld <= slot_vld[raddr];
      if (mem_we) begin
        slot_vld[idx] <= 1'b1;
      end
    end
  end

  assign slot_rd = rvld ? rdata : '0;

  // Per-slot decision for the current command.
  ttt_slot_update u_update (
    .cmd             (cmd_q),
    .slot            (slot_rd),
    .task_id         (id_q),
    .period          (period_q),
    .start_delay     (delay_q),
    .repeat_periodic (rep_q),
    .tick_count      (tick_counter),
    .found           (status_q == ST_OK),
    .room            (n_cnt < CNT_W'(MAX_RESULTS)),
    .upd             (upd)
  );

  assign mem_we    = (state == S_SCAN) && upd.we;
  assign occ_after = any_occ || upd.occupied;

  // Sequencer, table-wide state and result registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      tick_counter    <= '0;
      ticking_enabled <= 1'b0;
      strobe          <= 1'b0;
      pend_valid      <= 1'b0;
      n_cnt           <= '0;
      any_occ         <= 1'b0;
      status_q        <= ST_OK;
      idx             <= '0;
    end else begin
      strobe <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            cmd_q      <= cmd_t'(cmd);
            id_q       <= task_id;
            period_q   <= period;
            delay_q    <= start_delay;
            rep_q      <= repeat_periodic;
            idx        <= '0;
            any_occ    <= 1'b0;
            n_cnt      <= '0;
            pend_valid <= 1'b0;
            status_q   <= ST_OK;
            state      <= S_SCAN;
            case (cmd_t'(cmd))
              CMD_ADD: begin
                status_q        <= ST_FULL;
                ticking_enabled <= 1'b1;
              end
              CMD_REMOVE: begin
                status_q <= ST_NOT_FOUND;
              end
              CMD_TICK: begin
                if (ticking_enabled) begin
                  tick_counter <= tick_counter + TIME_W'(1);
                end else begin
                  // Ignored tick: answer right away and stay idle.
                  state       <= S_IDLE;
                  strobe      <= 1'b1;
                  status      <= ST_OK;
                  run_valid   <= 1'b0;
                  run_task_id <= '0;
                  last        <= 1'b1;
                  ticking_on  <= ticking_enabled;
                  tick_count  <= tick_counter;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_SCAN: begin
          idx <= idx + IDX_W'(1);
          if (idx == LAST_IDX) begin
            state <= S_FINISH;
          end
          case (cmd_q)
            CMD_ADD: begin
              if (upd.hit) begin
                status_q <= ST_OK;
                state    <= S_FINISH;
              end
            end
            CMD_REMOVE: begin
              if (upd.hit) begin
                status_q <= ST_OK;
              end
              any_occ <= occ_after;
              if (idx == LAST_IDX && !occ_after) begin
                ticking_enabled <= 1'b0;
              end
            end
            CMD_DISPATCH: begin
              if (upd.hit) begin
                // The held beat is not the final one, so it goes out now.
                if (pend_valid) begin
                  strobe      <= 1'b1;
                  status      <= ST_OK;
                  run_valid   <= 1'b1;
                  run_task_id <= pend_id;
                  last        <= 1'b0;
                  ticking_on  <= ticking_enabled;
                  tick_count  <= tick_counter;
                end
                pend_valid <= 1'b1;
                pend_id    <= slot_rd.id;
                n_cnt      <= n_cnt + CNT_W'(1);
                if (n_cnt + CNT_W'(1) == CNT_W'(MAX_RESULTS)) begin
                  state <= S_FINISH;
                end
              end
            end
            default: begin
            end
          endcase
        end
        S_FINISH: begin
          // Final beat of the command.
          state      <= S_IDLE;
          strobe     <= 1'b1;
          last       <= 1'b1;
          ticking_on <= ticking_enabled;
          tick_count <= tick_counter;
          if (cmd_q == CMD_DISPATCH) begin
            status      <= ST_OK;
            run_valid   <= pend_valid;
            run_task_id <= pend_valid ? pend_id : '0;
          end else begin
            status      <= status_q;
            run_valid   <= 1'b0;
            run_task_id <= '0;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The final beat of a command always leaves the sequencer idle.
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    strobe && last |-> state == S_IDLE)
    else $error("final beat while sequencer still busy");

  // The scan pointer never leaves the table.
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> idx <= LAST_IDX)
    else $error("scan pointer beyond last slot");

  // No more dispatch beats than the per-command limit.
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    n_cnt <= CNT_W'(MAX_RESULTS))
    else $error("dispatch count beyond limit");

  // The tick counter moves only while ticking is on.
  a_tick_gate: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && !$stable(tick_counter) |-> $past(ticking_enabled))
    else $error("tick counter moved while ticking off");

endmodule
